// ===== src/hsvrgb_pkg.sv =====
`default_nettype none
package hsvrgb_pkg;

	typedef struct packed {
		logic [11:0] hue;
		logic [9:0]  saturation;
		logic [9:0]  brightness;
	} hsv_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	// clamp limits
	localparam int HUE_MAX     = 360;
	localparam int PERMILLE    = 1000;
	// per mille to percent: x * 205 >> 11 is exact for x up to 1028
	localparam int DIV10_MUL   = 205;
	localparam int DIV10_SHIFT = 11;
	localparam int SECTOR_SPAN = 60;
	localparam int PERCENT     = 100;

	// numerators over 600000 = 64 * 9375
	localparam int MX_SCALE    = 6000;
	localparam int MN_SCALE    = 60;
	localparam int DEN_SHIFT   = 6;
	localparam int DEN_ODD     = 9375;
	localparam int RECIP_SHIFT = 32;
	localparam longint RECIP_MUL = (64'd1 << RECIP_SHIFT) / DEN_ODD;

	// result lanes of the divide stages
	localparam int LANES   = 4;
	localparam int LANE_MX = 0;
	localparam int LANE_MN = 1;
	localparam int LANE_UP = 2;
	localparam int LANE_DN = 3;

	localparam int PIPE_DEPTH = 6;

endpackage
`default_nettype wire

// ===== src/hsv_to_rgb_converter.sv =====
`default_nettype none
// Throughput: one beat per cycle while the output is not stalled; six register stages, each with its own valid bit.
// A stalled output holds the last stage and the full stages directly behind it; earlier stages keep filling bubbles.
// The longest stage path is one 22 x 19 bit reciprocal multiply per lane.
// Reset (arst_n low, asynchronous) clears the valid bits; payload is not reset.
module hsv_to_rgb_converter (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 hsv_valid,
	output logic                hsv_stall,
	input  hsvrgb_pkg::hsv_t    hsv,
	output logic                rgb_valid,
	input  wire                 rgb_stall,
	output hsvrgb_pkg::rgb_t    rgb
);
	import hsvrgb_pkg::*;

	// stage enables: a stage loads when it is empty or the next one loads
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	assign en_s6     = !valid_s6 || !rgb_stall;
	assign en_s5     = !valid_s5 || en_s6;
	assign en_s4     = !valid_s4 || en_s5;
	assign en_s3     = !valid_s3 || en_s4;
	assign en_s2     = !valid_s2 || en_s3;
	assign en_s1     = !valid_s1 || en_s2;
	assign hsv_stall = !en_s1;
	assign rgb_valid = valid_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= hsv_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
		end
	end

	// ---------------- stage 1: clamp, percent, sector ----------------
	logic [8:0]  h_c;
	logic [9:0]  s_c, v_c;
	logic [17:0] s_prod, v_prod;
	logic [6:0]  s_pct, v_pct;
	sector_t     sec_c;
	logic [5:0]  d_c;

	always_comb begin
		h_c = (hsv.hue > 12'(HUE_MAX)) ? 9'(HUE_MAX) : hsv.hue[8:0];
		s_c = (hsv.saturation > 10'(PERMILLE)) ? 10'(PERMILLE) : hsv.saturation;
		v_c = (hsv.brightness > 10'(PERMILLE)) ? 10'(PERMILLE) : hsv.brightness;
		s_prod = 18'(s_c) * 18'(DIV10_MUL);
		v_prod = 18'(v_c) * 18'(DIV10_MUL);
		s_pct  = 7'(s_prod >> DIV10_SHIFT);
		v_pct  = 7'(v_prod >> DIV10_SHIFT);
		// a full circle wraps back onto red with no offset
		priority if (h_c >= 9'(HUE_MAX)) begin
			sec_c = SEC_RED;
			d_c   = 6'd0;
		end else if (h_c >= 9'(5 * SECTOR_SPAN)) begin
			sec_c = SEC_MAGENTA;
			d_c   = 6'(h_c - 9'(5 * SECTOR_SPAN));
		end else if (h_c >= 9'(4 * SECTOR_SPAN)) begin
			sec_c = SEC_BLUE;
			d_c   = 6'(h_c - 9'(4 * SECTOR_SPAN));
		end else if (h_c >= 9'(3 * SECTOR_SPAN)) begin
			sec_c = SEC_CYAN;
			d_c   = 6'(h_c - 9'(3 * SECTOR_SPAN));
		end else if (h_c >= 9'(2 * SECTOR_SPAN)) begin
			sec_c = SEC_GREEN;
			d_c   = 6'(h_c - 9'(2 * SECTOR_SPAN));
		end else if (h_c >= 9'(SECTOR_SPAN)) begin
			sec_c = SEC_YELLOW;
			d_c   = 6'(h_c - 9'(SECTOR_SPAN));
		end else begin
			sec_c = SEC_RED;
			d_c   = h_c[5:0];
		end
	end

	logic [6:0] s_s1, v_s1;
	logic [5:0] d_s1;
	sector_t    sec_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			s_s1   <= s_pct;
			v_s1   <= v_pct;
			d_s1   <= d_c;
			sec_s1 <= sec_c;
		end
	end

	// ---------------- stage 2: base, s*d, 100-s ----------------
	logic [14:0] base_s2;
	logic [12:0] sd_s2;
	logic [6:0]  inv_s2;
	sector_t     sec_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			// v * 255 as v * 256 - v
			base_s2 <= {v_s1, 8'd0} - 15'(v_s1);
			sd_s2   <= 13'(s_s1) * 13'(d_s1);
			inv_s2  <= 7'(PERCENT) - s_s1;
			sec_s2  <= sec_s1;
		end
	end

	// ---------------- stage 3: products with base ----------------
	logic [21:0] p_mn_s3;
	logic [27:0] p_adj_s3, mx_n_s3;
	sector_t     sec_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			p_mn_s3  <= 22'(base_s2) * 22'(inv_s2);
			p_adj_s3 <= 28'(base_s2) * 28'(sd_s2);
			mx_n_s3  <= 28'(base_s2) * 28'(MX_SCALE);
			sec_s3   <= sec_s2;
		end
	end

	// ---------------- stage 4: numerators, drop the power of two ----------------
	logic [27:0] mn_n;
	logic [27:0] num [LANES];

	always_comb begin
		mn_n         = 28'(p_mn_s3) * 28'(MN_SCALE);
		num[LANE_MX] = mx_n_s3;
		num[LANE_MN] = mn_n;
		num[LANE_UP] = mn_n + p_adj_s3;
		num[LANE_DN] = mx_n_s3 - p_adj_s3;
	end

	logic [21:0] x_s4 [LANES];
	sector_t     sec_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int i = 0; i < LANES; i++) begin
				x_s4[i] <= 22'(num[i] >> DEN_SHIFT);
			end
			sec_s4 <= sec_s3;
		end
	end

	// ---------------- stage 5: reciprocal estimate, low by at most one ----------------
	logic [40:0] recip_prod [LANES];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			recip_prod[i] = 41'(x_s4[i]) * 41'(RECIP_MUL);
		end
	end

	logic [7:0]  q0_s5 [LANES];
	logic [21:0] x_s5  [LANES];
	sector_t     sec_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			for (int i = 0; i < LANES; i++) begin
				q0_s5[i] <= 8'(recip_prod[i] >> RECIP_SHIFT);
				x_s5[i]  <= x_s4[i];
			end
			sec_s5 <= sec_s4;
		end
	end

	// ---------------- stage 6: correct quotient, route to channels ----------------
	logic [21:0] rem  [LANES];
	logic [7:0]  quot [LANES];
	rgb_t        rgb_c;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			rem[i]  = x_s5[i] - 22'(q0_s5[i]) * 22'(DEN_ODD);
			quot[i] = (rem[i] >= 22'(DEN_ODD)) ? q0_s5[i] + 8'd1 : q0_s5[i];
		end
		unique case (sec_s5)
			SEC_RED: begin
				rgb_c = '{red: quot[LANE_MX], green: quot[LANE_UP], blue: quot[LANE_MN]};
			end
			SEC_YELLOW: begin
				rgb_c = '{red: quot[LANE_DN], green: quot[LANE_MX], blue: quot[LANE_MN]};
			end
			SEC_GREEN: begin
				rgb_c = '{red: quot[LANE_MN], green: quot[LANE_MX], blue: quot[LANE_UP]};
			end
			SEC_CYAN: begin
				rgb_c = '{red: quot[LANE_MN], green: quot[LANE_DN], blue: quot[LANE_MX]};
			end
			SEC_BLUE: begin
				rgb_c = '{red: quot[LANE_UP], green: quot[LANE_MN], blue: quot[LANE_MX]};
			end
			default: begin
				rgb_c = '{red: quot[LANE_MX], green: quot[LANE_MN], blue: quot[LANE_DN]};
			end
		endcase
	end

	rgb_t rgb_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			rgb_s6 <= rgb_c;
		end
	end

	assign rgb = rgb_s6;

endmodule
`default_nettype wire

// ===== src/hsvrgb_chk.sv =====
`default_nettype none
module hsvrgb_chk (
	input wire              clk,
	input wire              arst_n,
	input wire              hsv_valid,
	input wire              hsv_stall,
	input hsvrgb_pkg::hsv_t hsv,
	input wire              rgb_valid,
	input wire              rgb_stall,
	input hsvrgb_pkg::rgb_t rgb
);
	import hsvrgb_pkg::*;

	logic       in_beat, out_beat;
	logic [2:0] count_q;

	assign in_beat  = hsv_valid && !hsv_stall;
	assign out_beat = rgb_valid && !rgb_stall;

	// track beats inside the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd0;
		end else begin
			count_q <= count_q + 3'(in_beat) - 3'(out_beat);
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid |-> count_q != 3'd0)
		else $error("rgb beat without a pending hsv beat");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(PIPE_DEPTH))
		else $error("more beats in flight than pipeline stages");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_stall |-> rgb_valid && rgb_stall)
		else $error("input stalled while output is free");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && rgb_stall |=> rgb_valid && $stable(rgb))
		else $error("stalled rgb beat dropped or changed");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv_stall |=> hsv_valid && $stable(hsv))
		else $error("stalled hsv beat dropped or changed");

endmodule

bind hsv_to_rgb_converter hsvrgb_chk u_hsvrgb_chk (.*);
`default_nettype wire
